FILE: rtl/cfbt_pkg.sv
// ----------------------------------------------------------------------------
// cfbt_pkg: shared types and constants of the config file byte tokenizer
// Payload structs of both channels, the record passed between the scanner
// and the output stage, result event codes and the fixed byte codes.
// ----------------------------------------------------------------------------
package cfbt_pkg;

    // Fixed byte codes
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Result event codes
    localparam logic [1:0] EV_BYTE       = 2'd0;
    localparam logic [1:0] EV_TOKEN_END  = 2'd1;
    localparam logic [1:0] EV_MISS_QUOTE = 2'd2;
    localparam logic [1:0] EV_STREAM_END = 2'd3;

    localparam logic [31:0] LINE_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
        logic       escapes_on;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  event_res;
        logic        is_quoted;
        logic        first_of_token;
        logic [31:0] line_number;
    } out_item_t;

    // Results of one input byte: one or two of them
    typedef struct packed {
        logic      two;
        out_item_t res0;
        out_item_t res1;
    } step_rec_t;

endpackage

FILE: rtl/config_file_byte_tokenizer_top.sv
// ----------------------------------------------------------------------------
// config_file_byte_tokenizer_top: byte tokenizer for configuration text
// One byte is accepted per cycle whenever the record queue has room; each
// byte yields zero, one or two results, and results leave one per cycle
// while m_ready is high. A byte that yields two results (token end or
// missing quote plus stream end, or an escaped byte in a string) sends
// both through the output one after the other, so the queue of
// QUEUE_DEPTH step records absorbs the difference and input stalls only
// when it fills. The queue is written at the input transfer edge and the
// output register loads from it once the output is free and no held
// result or older record is ahead. The comment byte register resets to '#'
// and is written with cfg_wr_en, taking effect on the next accepted byte.
// ----------------------------------------------------------------------------
module config_file_byte_tokenizer_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  cfbt_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cfbt_pkg::out_item_t m_data
);
    import cfbt_pkg::*;

    logic      accept;
    logic      push;
    step_rec_t push_rec;
    step_rec_t pop_rec;
    logic      pop;
    logic      full;
    logic      empty;

    assign s_ready = !full;
    assign accept  = s_valid && s_ready;

    cfbt_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .item        (s_data),
        .push        (push),
        .rec         (push_rec)
    );

    cfbt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .full     (full),
        .empty    (empty)
    );

    cfbt_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rec     (pop_rec),
        .empty   (empty),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: rtl/cfbt_front.sv
// ----------------------------------------------------------------------------
// cfbt_front: byte scanner
// Holds the scan state, classifies each accepted byte and builds the record
// of results that the byte causes. Records go to the queue.
// ----------------------------------------------------------------------------
module cfbt_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    input  logic                accept,
    input  cfbt_pkg::in_item_t  item,
    output logic                push,
    output cfbt_pkg::step_rec_t rec
);
    import cfbt_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE       = 3'd0,
        MODE_BARE       = 3'd1,
        MODE_BARE_ESC   = 3'd2,
        MODE_QUOTED     = 3'd3,
        MODE_QUOTED_ESC = 3'd4,
        MODE_COMMENT    = 3'd5,
        MODE_AFTER_CR   = 3'd6
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic        esc_reg, esc_next;
    logic        first_reg, first_next;
    logic [31:0] line_reg, line_next;
    logic [7:0]  comment_reg;

    logic [7:0]  c;
    logic        inc;
    logic [1:0]  nres;
    out_item_t   r0, r1;

    function automatic out_item_t make_res(input logic [7:0] b, input logic [1:0] ev,
                                           input logic q, input logic f);
        out_item_t r;
        r.out_byte       = b;
        r.event_res      = ev;
        r.is_quoted      = q;
        r.first_of_token = f;
        r.line_number    = '0;
        return r;
    endfunction

    assign c = item.in_byte;

    // Next scan state and results of the offered byte
    always_comb begin
        mode_next  = mode_reg;
        esc_next   = esc_reg;
        first_next = first_reg;
        inc        = 1'b0;
        nres       = 2'd0;
        r0         = make_res(8'd0, EV_STREAM_END, 1'b0, 1'b0);
        r1         = make_res(8'd0, EV_STREAM_END, 1'b0, 1'b0);
        if (item.end_of_input) begin
            case (mode_reg)
                MODE_BARE, MODE_BARE_ESC: begin
                    r0   = make_res(8'd0, EV_TOKEN_END, 1'b0, 1'b0);
                    nres = 2'd2;
                end
                MODE_QUOTED, MODE_QUOTED_ESC: begin
                    r0   = make_res(8'd0, EV_MISS_QUOTE, 1'b1, 1'b0);
                    nres = 2'd2;
                end
                MODE_COMMENT: begin
                    inc  = 1'b1;
                    nres = 2'd1;
                end
                default: begin
                    nres = 2'd1;
                end
            endcase
            mode_next  = MODE_IDLE;
            esc_next   = 1'b0;
            first_next = 1'b0;
        end else begin
            case (mode_reg)
                MODE_BARE: begin
                    if (c > CH_SPACE && c != CH_COMMA) begin
                        if (esc_reg && c == CH_BSLASH) begin
                            mode_next = MODE_BARE_ESC;
                        end else begin
                            r0         = make_res(c, EV_BYTE, 1'b0, first_reg);
                            nres       = 2'd1;
                            first_next = 1'b0;
                        end
                    end else begin
                        r0         = make_res(8'd0, EV_TOKEN_END, 1'b0, 1'b0);
                        nres       = 2'd1;
                        first_next = 1'b0;
                        if (c == CH_CR) begin
                            mode_next = MODE_AFTER_CR;
                        end else begin
                            inc       = (c == CH_LF);
                            mode_next = MODE_IDLE;
                        end
                    end
                end
                MODE_BARE_ESC: begin
                    r0         = make_res(c, EV_BYTE, 1'b0, first_reg);
                    nres       = 2'd1;
                    first_next = 1'b0;
                    mode_next  = MODE_BARE;
                end
                MODE_QUOTED: begin
                    if (c == CH_CR) begin
                        mode_next = MODE_QUOTED;
                    end else if (c == CH_QUOTE) begin
                        r0         = make_res(8'd0, EV_TOKEN_END, 1'b1, 1'b0);
                        nres       = 2'd1;
                        first_next = 1'b0;
                        mode_next  = MODE_IDLE;
                    end else if (c == CH_LF) begin
                        r0         = make_res(8'd0, EV_MISS_QUOTE, 1'b1, 1'b0);
                        nres       = 2'd1;
                        first_next = 1'b0;
                        inc        = 1'b1;
                        mode_next  = MODE_IDLE;
                    end else if (esc_reg && c == CH_BSLASH) begin
                        mode_next = MODE_QUOTED_ESC;
                    end else begin
                        r0         = make_res(c, EV_BYTE, 1'b1, first_reg);
                        nres       = 2'd1;
                        first_next = 1'b0;
                    end
                end
                MODE_QUOTED_ESC: begin
                    mode_next  = MODE_QUOTED;
                    first_next = 1'b0;
                    if (c == CH_QUOTE || c == CH_BSLASH) begin
                        r0   = make_res(c, EV_BYTE, 1'b1, first_reg);
                        nres = 2'd1;
                    end else if (c == CH_LF) begin
                        // backslash kept, newline closes with a missing quote
                        r0        = make_res(CH_BSLASH, EV_BYTE, 1'b1, first_reg);
                        r1        = make_res(8'd0, EV_MISS_QUOTE, 1'b1, 1'b0);
                        nres      = 2'd2;
                        inc       = 1'b1;
                        mode_next = MODE_IDLE;
                    end else begin
                        r0   = make_res(CH_BSLASH, EV_BYTE, 1'b1, first_reg);
                        r1   = make_res(c, EV_BYTE, 1'b1, 1'b0);
                        nres = 2'd2;
                    end
                end
                MODE_COMMENT: begin
                    if (c == CH_LF) begin
                        inc       = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_AFTER_CR: begin
                    inc       = (c == CH_LF);
                    mode_next = MODE_IDLE;
                end
                default: begin
                    // between tokens; the unused code acts the same
                    if (c == comment_reg) begin
                        mode_next = MODE_COMMENT;
                    end else if (c == CH_QUOTE) begin
                        esc_next   = item.escapes_on;
                        first_next = 1'b1;
                        mode_next  = MODE_QUOTED;
                    end else if (c == CH_COMMA) begin
                        mode_next = MODE_IDLE;
                    end else if (c > CH_SPACE) begin
                        esc_next = item.escapes_on;
                        if (item.escapes_on && c == CH_BSLASH) begin
                            first_next = 1'b1;
                            mode_next  = MODE_BARE_ESC;
                        end else begin
                            r0         = make_res(c, EV_BYTE, 1'b0, 1'b1);
                            nres       = 2'd1;
                            first_next = 1'b0;
                            mode_next  = MODE_BARE;
                        end
                    end else if (c == CH_CR) begin
                        mode_next = MODE_AFTER_CR;
                    end else begin
                        inc       = (c == CH_LF);
                        mode_next = MODE_IDLE;
                    end
                end
            endcase
        end
    end

    // Saturating line count
    assign line_next = (inc && line_reg != LINE_MAX) ? line_reg + 32'd1 : line_reg;

    // Record toward the queue
    always_comb begin
        rec                  = '0;
        rec.two              = (nres == 2'd2);
        rec.res0             = r0;
        rec.res1             = r1;
        rec.res0.line_number = line_next;
        rec.res1.line_number = line_next;
    end

    assign push = accept && (nres != 2'd0);

    // Hold scan state and the comment byte register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            esc_reg     <= 1'b0;
            first_reg   <= 1'b0;
            line_reg    <= '0;
            comment_reg <= CH_HASH;
        end else begin
            if (accept) begin
                mode_reg  <= mode_next;
                esc_reg   <= esc_next;
                first_reg <= first_next;
                line_reg  <= line_next;
            end
            if (cfg_wr_en) begin
                comment_reg <= cfg_wr_data;
            end
        end
    end

endmodule

FILE: rtl/cfbt_queue.sv
// ----------------------------------------------------------------------------
// cfbt_queue: short queue of step records
// Decouples the scanner from the output stage so each side stalls on its own.
// ----------------------------------------------------------------------------
module cfbt_queue #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  cfbt_pkg::step_rec_t push_rec,
    input  logic                pop,
    output cfbt_pkg::step_rec_t pop_rec,
    output logic                full,
    output logic                empty
);
    import cfbt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    step_rec_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_rec = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store records
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

FILE: rtl/cfbt_back.sv
// ----------------------------------------------------------------------------
// cfbt_back: output stage
// Takes step records from the queue and sends their results one per
// transfer from a registered output, holding a second result aside.
// ----------------------------------------------------------------------------
module cfbt_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfbt_pkg::step_rec_t rec,
    input  logic                empty,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output cfbt_pkg::out_item_t m_data
);
    import cfbt_pkg::*;

    logic      out_valid_reg;
    out_item_t out_reg;
    logic      second_valid_reg;
    out_item_t second_reg;
    logic      load_ok;

    assign load_ok = !out_valid_reg || m_ready;
    assign pop     = load_ok && !second_valid_reg && !empty;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Drain the held result first, then the queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg    <= 1'b0;
            second_valid_reg <= 1'b0;
        end else if (load_ok) begin
            if (second_valid_reg) begin
                out_valid_reg    <= 1'b1;
                second_valid_reg <= 1'b0;
            end else if (!empty) begin
                out_valid_reg    <= 1'b1;
                second_valid_reg <= rec.two;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_ok) begin
            if (second_valid_reg) begin
                out_reg <= second_reg;
            end else if (!empty) begin
                out_reg    <= rec.res0;
                second_reg <= rec.res1;
            end
        end
    end

endmodule

FILE: rtl/cfbt_checker.sv
// ----------------------------------------------------------------------------
// cfbt_checker: port-level checks of the tokenizer
// Watches the result channel over time; bound to the top level below.
// ----------------------------------------------------------------------------
module cfbt_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input cfbt_pkg::out_item_t m_data
);
    import cfbt_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // Clear the output after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    // A byte right after a token end or a missing quote opens a new token
    a_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready &&
        (m_data.event_res == EV_TOKEN_END || m_data.event_res == EV_MISS_QUOTE)
        |=> !(m_valid && m_data.event_res == EV_BYTE) || m_data.first_of_token)
        else $error("token byte after token end not marked first");

    // Line numbers never go back from one transfer to the next
    a_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready
        |=> !m_valid || m_data.line_number >= $past(m_data.line_number))
        else $error("line number decreased");

endmodule

bind config_file_byte_tokenizer_top cfbt_checker u_cfbt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
